// ===== sv/ptbfa_pkg.sv =====
// ----------------------------------------------------------------------------
// ptbfa_pkg
// Shared types and constants of the page table best-fit allocator.
// ----------------------------------------------------------------------------
package ptbfa_pkg;

   localparam int PAGE_TOTAL_DEF = 256;
   localparam int CNT_W          = 9;

   localparam logic [2:0] OP_FIND      = 3'd0;
   localparam logic [2:0] OP_ALLOC     = 3'd1;
   localparam logic [2:0] OP_FREE      = 3'd2;
   localparam logic [2:0] OP_SET_ID    = 3'd3;
   localparam logic [2:0] OP_CLR_ID    = 3'd4;
   localparam logic [2:0] OP_SET_SLOT  = 3'd5;
   localparam logic [2:0] OP_CLR_SLOT  = 3'd6;
   localparam logic [2:0] OP_DEACT_ALL = 3'd7;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_OOM       = 2'd2;

   localparam logic [2:0] TYPE_FREE = 3'd0;
   localparam logic [2:0] TYPE_HEAP = 3'd5;
   localparam int         LOCKED_IDX = 7;
   localparam int         ACTIVE_IDX = 6;
   localparam logic [7:0] RUN_MAX    = 8'd255;

   localparam logic [7:0] SMALL_LIMIT_RST = 8'd6;
   localparam logic [7:0] LOW_END_RST     = 8'd32;

   localparam int         CSR_ADDR_W          = 3;
   localparam logic [2:0] CSR_SMALL_LIMIT_ADR = 3'd0;
   localparam logic [2:0] CSR_LOW_END_ADR     = 3'd4;

   typedef enum logic [4:0] {
      UOP_NONE, UOP_CAPTURE, UOP_DISP, UOP_MOD, UOP_F_RD, UOP_F_CHK,
      UOP_RW_RD, UOP_RW_GET0, UOP_RW_WR, UOP_FR_RD, UOP_FR_CHK,
      UOP_RL_RD, UOP_RL_GET0, UOP_RL_BK, UOP_RL_BKCHK, UOP_RL_FCHK, UOP_RL_FWR,
      UOP_AL_WIN, UOP_SC_INIT, UOP_SC_RD, UOP_SC_CHK, UOP_SC_END,
      UOP_AW_INIT, UOP_AW_RD, UOP_AW_CHK, UOP_AW_WR,
      UOP_DA_RD, UOP_DA_CHK, UOP_DA_WR, UOP_FIN, UOP_FIN_GET
   } uop_type;

   typedef struct packed {
      logic [2:0] op;
      logic       count_zero;
      logic       target_ok;
      logic       mod_done;
      logic       match;
      logic       find_last;
      logic       rw_same;
      logic       ptr_last;
      logic       type_zero;
      logic       rp_zero;
      logic       rp_last;
      logic       rel_match;
      logic       rel_ret_alloc;
      logic       sc_hit;
      logic       sc_last;
      logic       found;
      logic       strat_zero;
      logic       strat_last;
      logic       pass_whole;
      logic       aw_last;
   } stat_type;

endpackage

// ===== sv/ptbfa_if.sv =====
// ----------------------------------------------------------------------------
// ptbfa_req_if / ptbfa_rsp_if
// Valid/ready channels for requests and results of the allocator.
// ----------------------------------------------------------------------------
interface ptbfa_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] op;
   logic [2:0] res_type;
   logic [4:0] new_flags;
   logic [7:0] owner_id;
   logic [7:0] start_hint;
   logic [7:0] page_count;
   logic [7:0] target_slot;

   modport source (output valid, op, res_type, new_flags, owner_id, start_hint,
                   page_count, target_slot, input ready);
   modport sink (input valid, op, res_type, new_flags, owner_id, start_hint,
                 page_count, target_slot, output ready);
endinterface

interface ptbfa_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] result_slot;
   logic [1:0] status;
   logic [7:0] slot_flags;
   logic       reclaimed_locked;

   modport source (output valid, result_slot, status, slot_flags, reclaimed_locked,
                   input ready);
   modport sink (input valid, result_slot, status, slot_flags, reclaimed_locked,
                 output ready);
endinterface

// ===== sv/ptbfa_ram.sv =====
// ----------------------------------------------------------------------------
// ptbfa_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module ptbfa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;
endmodule

// ===== sv/ptbfa_csr.sv =====
// ----------------------------------------------------------------------------
// ptbfa_csr
// APB-style configuration registers for the allocation windows.
// ----------------------------------------------------------------------------
module ptbfa_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [ptbfa_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                    pwdata,
   output logic [31:0]                    prdata,
   output logic                           pready,
   output logic [7:0]                     small_limit,
   output logic [7:0]                     low_end
);
   logic [7:0] small_limit_ff, small_limit_in;
   logic [7:0] low_end_ff, low_end_in;
   logic       wr;

   assign wr = psel && penable && pwrite;

   always_comb begin
      small_limit_in = small_limit_ff;
      low_end_in     = low_end_ff;
      if (wr && paddr == ptbfa_pkg::CSR_SMALL_LIMIT_ADR) begin
         small_limit_in = pwdata[7:0];
      end
      if (wr && paddr == ptbfa_pkg::CSR_LOW_END_ADR) begin
         low_end_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         small_limit_ff <= ptbfa_pkg::SMALL_LIMIT_RST;
         low_end_ff     <= ptbfa_pkg::LOW_END_RST;
      end else begin
         small_limit_ff <= small_limit_in;
         low_end_ff     <= low_end_in;
      end
   end

   always_comb begin
      prdata = 32'd0;
      if (paddr == ptbfa_pkg::CSR_SMALL_LIMIT_ADR) begin
         prdata = {24'd0, small_limit_ff};
      end else if (paddr == ptbfa_pkg::CSR_LOW_END_ADR) begin
         prdata = {24'd0, low_end_ff};
      end
   end

   assign pready      = 1'b1;
   assign small_limit = small_limit_ff;
   assign low_end     = low_end_ff;
endmodule

// ===== sv/ptbfa_dp.sv =====
// ----------------------------------------------------------------------------
// ptbfa_dp
// Datapath: page table memory, scan and walk registers, result registers.
// ----------------------------------------------------------------------------
module ptbfa_dp #(
   parameter int PAGE_TOTAL = ptbfa_pkg::PAGE_TOTAL_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  ptbfa_pkg::uop_type  uop,
   output ptbfa_pkg::stat_type stat,
   input  logic [2:0]          op,
   input  logic [2:0]          res_type,
   input  logic [4:0]          new_flags,
   input  logic [7:0]          owner_id,
   input  logic [7:0]          start_hint,
   input  logic [7:0]          page_count,
   input  logic [7:0]          target_slot,
   input  logic [7:0]          small_limit,
   input  logic [7:0]          low_end,
   output logic [7:0]          result_slot,
   output logic [1:0]          status,
   output logic [7:0]          slot_flags,
   output logic                reclaimed_locked
);
   localparam int              AW = $clog2(PAGE_TOTAL);
   localparam int              CW = ptbfa_pkg::CNT_W;
   localparam logic [CW-1:0]   NP = CW'(PAGE_TOTAL);
   localparam logic [CW-1:0]   ONE = CW'(1);
   localparam logic [1:0]      STRAT_FREE = 2'd0;
   localparam logic [1:0]      STRAT_UNLOCKED = 2'd1;
   localparam logic [1:0]      STRAT_LOCKED = 2'd2;

   logic [2:0]    op_ff, op_in;
   logic [2:0]    type_ff, type_in;
   logic [4:0]    flags_ff, flags_in;
   logic [7:0]    id_ff, id_in;
   logic [7:0]    hint_ff, hint_in;
   logic [7:0]    count_ff, count_in;
   logic [7:0]    target_ff, target_in;
   logic [CW-1:0] ptr_ff, ptr_in;
   logic [CW-1:0] n_ff, n_in;
   logic [CW-1:0] rp_ff, rp_in;
   logic [CW-1:0] ap_ff, ap_in;
   logic [7:0]    i_ff, i_in;
   logic [7:0]    run_ff, run_in;
   logic [CW-1:0] cur_ff, cur_in;
   logic [7:0]    best_ff, best_in;
   logic [CW-1:0] bstart_ff, bstart_in;
   logic          found_ff, found_in;
   logic [1:0]    strat_ff, strat_in;
   logic          pass_ff, pass_in;
   logic [CW-1:0] s_ff, s_in;
   logic [CW-1:0] e_ff, e_in;
   logic [7:0]    old_kind_ff, old_kind_in;
   logic [7:0]    old_owner_ff, old_owner_in;
   logic [7:0]    nk_ff, nk_in;
   logic [2:0]    rel_type_ff, rel_type_in;
   logic [7:0]    rel_id_ff, rel_id_in;
   logic          rel_ret_ff, rel_ret_in;
   logic          locked_ff, locked_in;
   logic [7:0]    rslot_ff, rslot_in;
   logic [1:0]    status_ff, status_in;
   logic [7:0]    sflags_ff, sflags_in;

   logic [PAGE_TOTAL-1:0] valid_ff;
   logic                  valid_q_ff;
   logic                  ram_we;
   logic [AW-1:0]         ram_addr;
   logic [15:0]           ram_wdata;
   logic [15:0]           ram_rdata;
   logic [7:0]            rd_kind;
   logic [7:0]            rd_owner;

   logic          target_ok;
   logic [CW-1:0] ptr_inc;
   logic [CW-1:0] rp_dec;
   logic          acc;
   logic [7:0]    run_nx;
   logic [CW-1:0] cur_nx;
   logic          better_old;
   logic          better_last;
   logic          sc_last;
   logic          small_req;
   logic [CW-1:0] lwe;
   logic [CW-1:0] win_s;
   logic [CW-1:0] win_e;
   logic          set_mode;

   function automatic logic accept_page(input logic [7:0] k, input logic [1:0] st);
      logic ok;
      ok = (k == 8'd0);
      if (st == STRAT_UNLOCKED) begin
         ok = ok || (k[ptbfa_pkg::LOCKED_IDX] == 1'b0 && k[ptbfa_pkg::ACTIVE_IDX] == 1'b0);
      end else if (st == STRAT_LOCKED) begin
         ok = ok || (k[ptbfa_pkg::ACTIVE_IDX] == 1'b0);
      end
      return ok;
   endfunction

   ptbfa_ram #(.WIDTH(16), .DEPTH(PAGE_TOTAL)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   // unwritten pages read as free
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         valid_q_ff <= 1'b0;
      end else begin
         valid_q_ff <= valid_ff[ram_addr];
         if (ram_we) begin
            valid_ff[ram_addr] <= 1'b1;
         end
      end
   end

   assign rd_kind  = valid_q_ff ? ram_rdata[15:8] : 8'd0;
   assign rd_owner = valid_q_ff ? ram_rdata[7:0] : 8'd0;

   assign target_ok = CW'(target_ff) < NP;
   assign ptr_inc   = ptr_ff + ONE;
   assign rp_dec    = rp_ff - ONE;
   assign set_mode  = (op_ff == ptbfa_pkg::OP_SET_ID) || (op_ff == ptbfa_pkg::OP_SET_SLOT);

   // best-fit scan step
   assign acc    = accept_page(rd_kind, strat_ff);
   assign run_nx = acc ? run_ff + 8'd1 : 8'd0;
   assign cur_nx = (acc && run_ff == 8'd0) ? ptr_ff : cur_ff;
   assign sc_last = (ptr_inc == e_ff);
   assign better_old = !acc && run_ff >= count_ff && (!found_ff || run_ff < best_ff);
   assign better_last = sc_last && run_nx >= count_ff && (!found_ff || run_nx < best_ff);

   // window selection
   assign small_req = count_ff < small_limit;
   assign lwe       = CW'(low_end);
   always_comb begin
      if (small_req) begin
         win_s = '0;
         win_e = (low_end == 8'd0 || lwe > NP) ? NP : lwe;
      end else begin
         win_s = lwe;
         win_e = NP;
      end
   end

   always_comb begin
      ram_addr  = ptr_ff[AW-1:0];
      ram_we    = 1'b0;
      ram_wdata = {nk_ff, old_owner_ff};
      unique case (uop)
         ptbfa_pkg::UOP_FR_RD, ptbfa_pkg::UOP_FIN: ram_addr = target_ff[AW-1:0];
         ptbfa_pkg::UOP_RL_RD: ram_addr = rp_ff[AW-1:0];
         ptbfa_pkg::UOP_RL_BK: ram_addr = rp_dec[AW-1:0];
         ptbfa_pkg::UOP_RL_FWR: begin
            ram_addr  = rp_ff[AW-1:0];
            ram_we    = 1'b1;
            ram_wdata = 16'd0;
         end
         ptbfa_pkg::UOP_AW_RD: ram_addr = ap_ff[AW-1:0];
         ptbfa_pkg::UOP_AW_WR: begin
            ram_addr  = ap_ff[AW-1:0];
            ram_we    = 1'b1;
            ram_wdata = {flags_ff, type_ff, id_ff};
         end
         ptbfa_pkg::UOP_RW_WR, ptbfa_pkg::UOP_DA_WR: ram_we = 1'b1;
         default: ram_addr = ptr_ff[AW-1:0];
      endcase
   end

   always_comb begin
      op_in        = op_ff;
      type_in      = type_ff;
      flags_in     = flags_ff;
      id_in        = id_ff;
      hint_in      = hint_ff;
      count_in     = count_ff;
      target_in    = target_ff;
      ptr_in       = ptr_ff;
      n_in         = n_ff;
      rp_in        = rp_ff;
      ap_in        = ap_ff;
      i_in         = i_ff;
      run_in       = run_ff;
      cur_in       = cur_ff;
      best_in      = best_ff;
      bstart_in    = bstart_ff;
      found_in     = found_ff;
      strat_in     = strat_ff;
      pass_in      = pass_ff;
      s_in         = s_ff;
      e_in         = e_ff;
      old_kind_in  = old_kind_ff;
      old_owner_in = old_owner_ff;
      nk_in        = nk_ff;
      rel_type_in  = rel_type_ff;
      rel_id_in    = rel_id_ff;
      rel_ret_in   = rel_ret_ff;
      locked_in    = locked_ff;
      rslot_in     = rslot_ff;
      status_in    = status_ff;
      sflags_in    = sflags_ff;
      unique case (uop)
         ptbfa_pkg::UOP_CAPTURE: begin
            op_in     = op;
            type_in   = res_type;
            flags_in  = new_flags;
            id_in     = owner_id;
            hint_in   = start_hint;
            count_in  = page_count;
            target_in = target_slot;
            locked_in = 1'b0;
            rslot_in  = 8'd0;
            status_in = ptbfa_pkg::ST_OK;
         end
         ptbfa_pkg::UOP_DISP: begin
            n_in = '0;
            unique case (op_ff)
               ptbfa_pkg::OP_FREE: begin
                  rslot_in = target_ff;
                  if (!target_ok) begin
                     status_in = ptbfa_pkg::ST_NOT_FOUND;
                  end
               end
               ptbfa_pkg::OP_SET_SLOT, ptbfa_pkg::OP_CLR_SLOT: begin
                  rslot_in = target_ff;
                  ptr_in   = CW'(target_ff);
               end
               ptbfa_pkg::OP_DEACT_ALL: ptr_in = '0;
               default: ptr_in = CW'(hint_ff);
            endcase
         end
         ptbfa_pkg::UOP_MOD: begin
            if (ptr_ff >= NP) begin
               ptr_in = ptr_ff - NP;
            end
         end
         ptbfa_pkg::UOP_F_CHK: begin
            if (rd_owner == id_ff && rd_kind[2:0] == type_ff) begin
               rslot_in = ptr_ff[7:0];
            end else begin
               n_in   = n_ff + ONE;
               ptr_in = (ptr_inc == NP) ? '0 : ptr_inc;
               if (n_ff == NP - ONE) begin
                  status_in = ptbfa_pkg::ST_NOT_FOUND;
               end
            end
         end
         ptbfa_pkg::UOP_RW_GET0: begin
            old_kind_in  = rd_kind;
            old_owner_in = rd_owner;
            nk_in = set_mode ? {rd_kind[7:3] | flags_ff, rd_kind[2:0]}
                             : {rd_kind[7:3] & ~flags_ff, rd_kind[2:0]};
         end
         ptbfa_pkg::UOP_RW_WR, ptbfa_pkg::UOP_DA_WR: ptr_in = ptr_inc;
         ptbfa_pkg::UOP_FR_CHK: begin
            rp_in      = CW'(target_ff);
            rel_ret_in = 1'b0;
            if (rd_kind[2:0] == ptbfa_pkg::TYPE_FREE) begin
               status_in = ptbfa_pkg::ST_NOT_FOUND;
            end
         end
         ptbfa_pkg::UOP_RL_GET0: begin
            rel_type_in = rd_kind[2:0];
            rel_id_in   = rd_owner;
         end
         ptbfa_pkg::UOP_RL_BKCHK: begin
            if (rd_kind[2:0] == rel_type_ff && rd_owner == rel_id_ff) begin
               rp_in = rp_dec;
            end
         end
         ptbfa_pkg::UOP_RL_FCHK: begin
            if (rd_kind[2:0] == rel_type_ff && rd_owner == rel_id_ff &&
                rd_kind[ptbfa_pkg::LOCKED_IDX]) begin
               locked_in = 1'b1;
            end
         end
         ptbfa_pkg::UOP_RL_FWR: rp_in = rp_ff + ONE;
         ptbfa_pkg::UOP_AL_WIN: begin
            strat_in = STRAT_FREE;
            if (win_s < win_e) begin
               s_in    = win_s;
               e_in    = win_e;
               pass_in = 1'b0;
            end else begin
               s_in    = '0;
               e_in    = NP;
               pass_in = 1'b1;
            end
         end
         ptbfa_pkg::UOP_SC_INIT: begin
            ptr_in    = s_ff;
            run_in    = 8'd0;
            cur_in    = '0;
            best_in   = 8'd0;
            bstart_in = '0;
            found_in  = 1'b0;
         end
         ptbfa_pkg::UOP_SC_CHK: begin
            if (run_nx == ptbfa_pkg::RUN_MAX) begin
               bstart_in = cur_nx;
               found_in  = 1'b1;
            end else begin
               run_in = run_nx;
               cur_in = cur_nx;
               ptr_in = ptr_inc;
               if (better_old) begin
                  found_in  = 1'b1;
                  best_in   = run_ff;
                  bstart_in = cur_ff;
               end else if (better_last) begin
                  found_in  = 1'b1;
                  best_in   = run_nx;
                  bstart_in = cur_nx;
               end
            end
         end
         ptbfa_pkg::UOP_SC_END: begin
            if (!found_ff) begin
               if (strat_ff != STRAT_LOCKED) begin
                  strat_in = strat_ff + 2'd1;
               end else if (!pass_ff) begin
                  strat_in = STRAT_FREE;
                  pass_in  = 1'b1;
                  s_in     = '0;
                  e_in     = NP;
               end else begin
                  status_in = ptbfa_pkg::ST_OOM;
                  rslot_in  = 8'd0;
               end
            end
         end
         ptbfa_pkg::UOP_AW_INIT: begin
            ap_in = bstart_ff;
            i_in  = 8'd0;
         end
         ptbfa_pkg::UOP_AW_CHK: begin
            if (rd_kind[ptbfa_pkg::LOCKED_IDX]) begin
               locked_in = 1'b1;
            end
            rp_in      = ap_ff;
            rel_ret_in = 1'b1;
         end
         ptbfa_pkg::UOP_AW_WR: begin
            ap_in = ap_ff + ONE;
            i_in  = i_ff + 8'd1;
            if (i_ff + 8'd1 == count_ff) begin
               rslot_in = bstart_ff[7:0];
            end
         end
         ptbfa_pkg::UOP_DA_CHK: begin
            old_owner_in = rd_owner;
            nk_in = (rd_kind[2:0] == ptbfa_pkg::TYPE_HEAP) ? rd_kind
                                                           : {2'b00, rd_kind[5:0]};
         end
         ptbfa_pkg::UOP_FIN: begin
            if (!target_ok) begin
               sflags_in = 8'd0;
            end
         end
         ptbfa_pkg::UOP_FIN_GET: sflags_in = rd_kind;
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      type_ff      <= type_in;
      flags_ff     <= flags_in;
      id_ff        <= id_in;
      hint_ff      <= hint_in;
      count_ff     <= count_in;
      target_ff    <= target_in;
      ptr_ff       <= ptr_in;
      n_ff         <= n_in;
      rp_ff        <= rp_in;
      ap_ff        <= ap_in;
      i_ff         <= i_in;
      run_ff       <= run_in;
      cur_ff       <= cur_in;
      best_ff      <= best_in;
      bstart_ff    <= bstart_in;
      found_ff     <= found_in;
      strat_ff     <= strat_in;
      pass_ff      <= pass_in;
      s_ff         <= s_in;
      e_ff         <= e_in;
      old_kind_ff  <= old_kind_in;
      old_owner_ff <= old_owner_in;
      nk_ff        <= nk_in;
      rel_type_ff  <= rel_type_in;
      rel_id_ff    <= rel_id_in;
      rel_ret_ff   <= rel_ret_in;
      locked_ff    <= locked_in;
      rslot_ff     <= rslot_in;
      status_ff    <= status_in;
      sflags_ff    <= sflags_in;
   end

   always_comb begin
      stat.op            = op_ff;
      stat.count_zero    = (count_ff == 8'd0);
      stat.target_ok     = target_ok;
      stat.mod_done      = (ptr_ff < NP);
      stat.match         = (rd_owner == id_ff && rd_kind[2:0] == type_ff);
      stat.find_last     = (n_ff == NP - ONE);
      stat.rw_same       = (rd_kind == old_kind_ff && rd_owner == old_owner_ff);
      stat.ptr_last      = (ptr_inc == NP);
      stat.type_zero     = (rd_kind[2:0] == ptbfa_pkg::TYPE_FREE);
      stat.rp_zero       = (rp_ff == '0);
      stat.rp_last       = (rp_ff + ONE == NP);
      stat.rel_match     = (rd_kind[2:0] == rel_type_ff && rd_owner == rel_id_ff);
      stat.rel_ret_alloc = rel_ret_ff;
      stat.sc_hit        = (run_nx == ptbfa_pkg::RUN_MAX);
      stat.sc_last       = sc_last;
      stat.found         = found_ff;
      stat.strat_zero    = (strat_ff == STRAT_FREE);
      stat.strat_last    = (strat_ff == STRAT_LOCKED);
      stat.pass_whole    = pass_ff;
      stat.aw_last       = (i_ff + 8'd1 == count_ff);
   end

   assign result_slot      = rslot_ff;
   assign status           = status_ff;
   assign slot_flags       = sflags_ff;
   assign reclaimed_locked = locked_ff && (op_ff == ptbfa_pkg::OP_ALLOC) &&
                             (status_ff == ptbfa_pkg::ST_OK);
endmodule

// ===== sv/ptbfa_ctrl.sv =====
// ----------------------------------------------------------------------------
// ptbfa_ctrl
// Controller: sequences table walks and scans through datapath commands.
// ----------------------------------------------------------------------------
module ptbfa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                rsp_ready,
   input  ptbfa_pkg::stat_type stat,
   output ptbfa_pkg::uop_type  uop,
   output logic                req_ready,
   output logic                rsp_valid
);
   localparam logic [5:0] S_IDLE     = 6'd0;
   localparam logic [5:0] S_DISP     = 6'd1;
   localparam logic [5:0] S_MOD      = 6'd2;
   localparam logic [5:0] S_F_RD     = 6'd3;
   localparam logic [5:0] S_F_CHK    = 6'd4;
   localparam logic [5:0] S_RW_RD0   = 6'd5;
   localparam logic [5:0] S_RW_GET0  = 6'd6;
   localparam logic [5:0] S_RW_WR    = 6'd7;
   localparam logic [5:0] S_RW_RD    = 6'd8;
   localparam logic [5:0] S_RW_CHK   = 6'd9;
   localparam logic [5:0] S_FR_RD    = 6'd10;
   localparam logic [5:0] S_FR_CHK   = 6'd11;
   localparam logic [5:0] S_RL_RD0   = 6'd12;
   localparam logic [5:0] S_RL_GET0  = 6'd13;
   localparam logic [5:0] S_RL_BK    = 6'd14;
   localparam logic [5:0] S_RL_BKCHK = 6'd15;
   localparam logic [5:0] S_RL_FRD   = 6'd16;
   localparam logic [5:0] S_RL_FCHK  = 6'd17;
   localparam logic [5:0] S_RL_FWR   = 6'd18;
   localparam logic [5:0] S_AL_WIN   = 6'd19;
   localparam logic [5:0] S_SC_INIT  = 6'd20;
   localparam logic [5:0] S_SC_RD    = 6'd21;
   localparam logic [5:0] S_SC_CHK   = 6'd22;
   localparam logic [5:0] S_SC_END   = 6'd23;
   localparam logic [5:0] S_AW_INIT  = 6'd24;
   localparam logic [5:0] S_AW_RD    = 6'd25;
   localparam logic [5:0] S_AW_CHK   = 6'd26;
   localparam logic [5:0] S_AW_WR    = 6'd27;
   localparam logic [5:0] S_DA_RD    = 6'd28;
   localparam logic [5:0] S_DA_CHK   = 6'd29;
   localparam logic [5:0] S_DA_WR    = 6'd30;
   localparam logic [5:0] S_FIN      = 6'd31;
   localparam logic [5:0] S_FIN_GET  = 6'd32;
   localparam logic [5:0] S_OUT      = 6'd33;

   logic [5:0] state_ff, state_in;
   logic [5:0] rel_done;

   assign rel_done = stat.rel_ret_alloc ? S_AW_WR : S_FIN;

   always_comb begin
      state_in = state_ff;
      uop      = ptbfa_pkg::UOP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               uop      = ptbfa_pkg::UOP_CAPTURE;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            uop = ptbfa_pkg::UOP_DISP;
            unique case (stat.op)
               ptbfa_pkg::OP_ALLOC: state_in = stat.count_zero ? S_FIN : S_AL_WIN;
               ptbfa_pkg::OP_FREE: state_in = stat.target_ok ? S_FR_RD : S_FIN;
               ptbfa_pkg::OP_SET_SLOT, ptbfa_pkg::OP_CLR_SLOT:
                  state_in = stat.target_ok ? S_RW_RD0 : S_FIN;
               ptbfa_pkg::OP_DEACT_ALL: state_in = S_DA_RD;
               default: state_in = S_MOD;
            endcase
         end
         S_MOD: begin
            uop = ptbfa_pkg::UOP_MOD;
            if (stat.mod_done) begin
               state_in = S_F_RD;
            end
         end
         S_F_RD: begin
            uop      = ptbfa_pkg::UOP_F_RD;
            state_in = S_F_CHK;
         end
         S_F_CHK: begin
            uop = ptbfa_pkg::UOP_F_CHK;
            if (stat.match) begin
               state_in = (stat.op == ptbfa_pkg::OP_FIND) ? S_FIN : S_RW_RD0;
            end else begin
               state_in = stat.find_last ? S_FIN : S_F_RD;
            end
         end
         S_RW_RD0: begin
            uop      = ptbfa_pkg::UOP_RW_RD;
            state_in = S_RW_GET0;
         end
         S_RW_GET0: begin
            uop      = ptbfa_pkg::UOP_RW_GET0;
            state_in = S_RW_WR;
         end
         S_RW_WR: begin
            uop      = ptbfa_pkg::UOP_RW_WR;
            state_in = stat.ptr_last ? S_FIN : S_RW_RD;
         end
         S_RW_RD: begin
            uop      = ptbfa_pkg::UOP_RW_RD;
            state_in = S_RW_CHK;
         end
         S_RW_CHK: state_in = stat.rw_same ? S_RW_WR : S_FIN;
         S_FR_RD: begin
            uop      = ptbfa_pkg::UOP_FR_RD;
            state_in = S_FR_CHK;
         end
         S_FR_CHK: begin
            uop      = ptbfa_pkg::UOP_FR_CHK;
            state_in = stat.type_zero ? S_FIN : S_RL_RD0;
         end
         S_RL_RD0: begin
            uop      = ptbfa_pkg::UOP_RL_RD;
            state_in = S_RL_GET0;
         end
         S_RL_GET0: begin
            uop      = ptbfa_pkg::UOP_RL_GET0;
            state_in = stat.type_zero ? rel_done : S_RL_BK;
         end
         S_RL_BK: begin
            uop      = ptbfa_pkg::UOP_RL_BK;
            state_in = stat.rp_zero ? S_RL_FRD : S_RL_BKCHK;
         end
         S_RL_BKCHK: begin
            uop      = ptbfa_pkg::UOP_RL_BKCHK;
            state_in = stat.rel_match ? S_RL_BK : S_RL_FRD;
         end
         S_RL_FRD: begin
            uop      = ptbfa_pkg::UOP_RL_RD;
            state_in = S_RL_FCHK;
         end
         S_RL_FCHK: begin
            uop      = ptbfa_pkg::UOP_RL_FCHK;
            state_in = stat.rel_match ? S_RL_FWR : rel_done;
         end
         S_RL_FWR: begin
            uop      = ptbfa_pkg::UOP_RL_FWR;
            state_in = stat.rp_last ? rel_done : S_RL_FRD;
         end
         S_AL_WIN: begin
            uop      = ptbfa_pkg::UOP_AL_WIN;
            state_in = S_SC_INIT;
         end
         S_SC_INIT: begin
            uop      = ptbfa_pkg::UOP_SC_INIT;
            state_in = S_SC_RD;
         end
         S_SC_RD: begin
            uop      = ptbfa_pkg::UOP_SC_RD;
            state_in = S_SC_CHK;
         end
         S_SC_CHK: begin
            uop = ptbfa_pkg::UOP_SC_CHK;
            if (stat.sc_hit) begin
               state_in = S_AW_INIT;
            end else begin
               state_in = stat.sc_last ? S_SC_END : S_SC_RD;
            end
         end
         S_SC_END: begin
            uop = ptbfa_pkg::UOP_SC_END;
            if (stat.found) begin
               state_in = S_AW_INIT;
            end else begin
               state_in = (stat.strat_last && stat.pass_whole) ? S_FIN : S_SC_INIT;
            end
         end
         S_AW_INIT: begin
            uop      = ptbfa_pkg::UOP_AW_INIT;
            state_in = stat.strat_zero ? S_AW_WR : S_AW_RD;
         end
         S_AW_RD: begin
            uop      = ptbfa_pkg::UOP_AW_RD;
            state_in = S_AW_CHK;
         end
         S_AW_CHK: begin
            uop      = ptbfa_pkg::UOP_AW_CHK;
            state_in = S_RL_RD0;
         end
         S_AW_WR: begin
            uop = ptbfa_pkg::UOP_AW_WR;
            if (stat.aw_last) begin
               state_in = S_FIN;
            end else begin
               state_in = stat.strat_zero ? S_AW_WR : S_AW_RD;
            end
         end
         S_DA_RD: begin
            uop      = ptbfa_pkg::UOP_DA_RD;
            state_in = S_DA_CHK;
         end
         S_DA_CHK: begin
            uop      = ptbfa_pkg::UOP_DA_CHK;
            state_in = S_DA_WR;
         end
         S_DA_WR: begin
            uop      = ptbfa_pkg::UOP_DA_WR;
            state_in = stat.ptr_last ? S_FIN : S_DA_RD;
         end
         S_FIN: begin
            uop      = ptbfa_pkg::UOP_FIN;
            state_in = stat.target_ok ? S_FIN_GET : S_OUT;
         end
         S_FIN_GET: begin
            uop      = ptbfa_pkg::UOP_FIN_GET;
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
endmodule

// ===== sv/page_table_best_fit_allocator.sv =====
// ----------------------------------------------------------------------------
// page_table_best_fit_allocator
// Page ownership table with find, best-fit allocate, free and flag updates.
// ----------------------------------------------------------------------------
// work: find reads and checks each page visited (up to PAGE_TOTAL), deactivate all
// reads, checks and writes every page, allocate scans up to 2 windows x 3 strategies
// plus the reclaim walks, all paced by one read per page on the table memory
// one request in flight; the next request is taken after the result is delivered
// reset: synchronous; every page reads as free at once through per-page valid bits
// ----------------------------------------------------------------------------
module page_table_best_fit_allocator #(
   parameter int PAGE_TOTAL = ptbfa_pkg::PAGE_TOTAL_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   ptbfa_req_if.sink                        req_chan,
   ptbfa_rsp_if.source                      rsp_chan,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [ptbfa_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]                      pwdata,
   output logic [31:0]                      prdata,
   output logic                             pready
);
   ptbfa_pkg::stat_type stat;
   ptbfa_pkg::uop_type  uop;
   logic [7:0]          small_limit;
   logic [7:0]          low_end;

   ptbfa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .small_limit (small_limit),
      .low_end     (low_end)
   );

   ptbfa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .uop       (uop),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid)
   );

   ptbfa_dp #(.PAGE_TOTAL(PAGE_TOTAL)) u_dp (
      .clock            (clock),
      .reset            (reset),
      .uop              (uop),
      .stat             (stat),
      .op               (req_chan.op),
      .res_type         (req_chan.res_type),
      .new_flags        (req_chan.new_flags),
      .owner_id         (req_chan.owner_id),
      .start_hint       (req_chan.start_hint),
      .page_count       (req_chan.page_count),
      .target_slot      (req_chan.target_slot),
      .small_limit      (small_limit),
      .low_end          (low_end),
      .result_slot      (rsp_chan.result_slot),
      .status           (rsp_chan.status),
      .slot_flags       (rsp_chan.slot_flags),
      .reclaimed_locked (rsp_chan.reclaimed_locked)
   );

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("request taken while a result is pending");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.status != 2'd3)
      else $error("undefined status code");

   a_locked_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.reclaimed_locked) |-> rsp_chan.status == ptbfa_pkg::ST_OK)
      else $error("reclaim flag on a failed request");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("ready held after a request was taken");
endmodule
